[sv/byte_ring_fifo_with_peek_macros.svh]
// Assertion macros shared by the checker of the byte ring FIFO.
// Needs clk and rst in the scope where a macro is used.
`ifndef BYTE_RING_FIFO_WITH_PEEK_MACROS_SVH
`define BYTE_RING_FIFO_WITH_PEEK_MACROS_SVH

// same-cycle implication
`define BRF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/brf_pkg.sv]
// Shared types and constants of the byte ring FIFO.
// No dependencies.
package brf_pkg;

  localparam int OP_W      = 3;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 10;
  localparam int OFF_W     = 10;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = 10;
  localparam int MOD_SHIFT = 20;
  localparam int RECIP_W   = 20;
  localparam int PROD_W    = OFF_W + RECIP_W;
  localparam int REM_W     = OFF_W + 1;

  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK8  = 3'd2;
  localparam logic [OP_W-1:0] OP_PEEK16 = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK32 = 3'd4;

  typedef struct packed {
    logic clr;
    logic latch;
    logic exec;
    logic mul1;
    logic mul2;
    logic modr;
    logic base;
    logic issue;
    logic cap;
    logic load;
  } brf_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            empty;
    logic            clr_last;
    logic            cap_last;
  } brf_sts_t;

endpackage

[sv/brf_dpath.sv]
// Datapath of the byte ring FIFO: byte store, pointers, peek address and result registers.
// Depends on brf_pkg; driven by brf_ctrl through brf_cmd_t.
module brf_dpath import brf_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  brf_cmd_t            cmd,
  output brf_sts_t            sts,
  input  logic [OP_W-1:0]     operation,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                burst_first,
  input  logic [LEN_W-1:0]    write_length,
  input  logic [OFF_W-1:0]    peek_offset,
  output logic [DATA_W-1:0]   read_data,
  output logic                data_valid,
  output logic                write_accepted,
  output logic [CNT_W-1:0]    occupancy,
  output logic [CNT_W-1:0]    free_space
);

  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = (PW > CNT_W) ? PW : CNT_W;
  localparam int BW    = ((PW > REM_W) ? PW : REM_W) + 1;
  localparam int RECIP = (1 << MOD_SHIFT) / DEPTH;
  localparam logic [PW-1:0]      LAST     = PW'(DEPTH - 1);
  localparam logic [PW:0]        DEPTH_PX = (PW + 1)'(DEPTH);
  localparam logic [RECIP_W-1:0] RECIP_V  = RECIP_W'(RECIP);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data;

  logic [PW-1:0]     wp;
  logic [PW-1:0]     rp;
  logic              brej;
  logic [PW-1:0]     clr_addr;

  logic [OP_W-1:0]   op_q;
  logic [BYTE_W-1:0] data_q;
  logic              first_q;
  logic [LEN_W-1:0]  len_q;
  logic [OFF_W-1:0]  off_q;

  logic [PROD_W-1:0] prod1;
  logic [REM_W-1:0]  qd;
  logic [REM_W-1:0]  offm;
  logic [PW-1:0]     paddr;
  logic [1:0]        cnt;
  logic [DATA_W-1:0] acc;
  logic              res_valid;
  logic              res_acc;

  logic [PW:0]       diff;
  logic [PW-1:0]     occ;
  logic [PW-1:0]     free;
  logic [CW-1:0]     occ_w;
  logic [CW-1:0]     free_w;
  logic              store;
  logic              do_write;
  logic              do_pop;
  logic [OFF_W-1:0]  q;
  logic [REM_W-1:0]  rem;
  logic [BW-1:0]     sumb;
  logic [PW-1:0]     ra;
  logic [1:0]        cnt_last;

  always_comb begin
    diff   = {1'b0, wp} - {1'b0, rp};
    occ    = diff[PW] ? PW'(diff + DEPTH_PX) : diff[PW-1:0];
    free   = LAST - occ;
    occ_w  = CW'(occ);
    free_w = CW'(free);
    if (first_q) begin
      store = free_w > CW'(len_q);
    end else begin
      store = !brej && (free != '0);
    end
    do_write = cmd.exec && (op_q == OP_WRITE) && store;
    do_pop   = cmd.exec && (op_q == OP_POP) && (occ != '0);
    q        = prod1[MOD_SHIFT +: OFF_W];
    rem      = {1'b0, off_q} - qd;
    sumb     = BW'(rp) + BW'(offm);
    ra       = cmd.exec ? rp : paddr;
    case (op_q)
      OP_PEEK16: cnt_last = 2'd1;
      OP_PEEK32: cnt_last = 2'd3;
      default:   cnt_last = 2'd0;
    endcase
  end

  assign sts.op       = op_q;
  assign sts.empty    = (occ == '0);
  assign sts.clr_last = (clr_addr == LAST);
  assign sts.cap_last = (cnt == cnt_last);

  always_ff @(posedge clk) begin
    if (cmd.clr) begin
      mem[clr_addr] <= '0;
    end else if (do_write) begin
      mem[wp] <= data_q;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      rp       <= '0;
      brej     <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (cmd.clr) begin
        clr_addr <= (clr_addr == LAST) ? '0 : clr_addr + 1'b1;
      end
      if (cmd.exec && (op_q == OP_WRITE) && first_q) begin
        brej <= !store;
      end
      if (do_write) begin
        wp <= (wp == LAST) ? '0 : wp + 1'b1;
      end
      if (do_pop) begin
        rp <= (rp == LAST) ? '0 : rp + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q      <= operation;
      data_q    <= data_byte;
      first_q   <= burst_first;
      len_q     <= write_length;
      off_q     <= peek_offset;
      acc       <= '0;
      cnt       <= '0;
      res_acc   <= 1'b0;
      res_valid <= (operation == OP_PEEK8) || (operation == OP_PEEK16)
                   || (operation == OP_PEEK32);
    end
    if (cmd.exec) begin
      res_acc <= do_write;
      if (do_pop) begin
        res_valid <= 1'b1;
      end
    end
    if (cmd.mul1) begin
      prod1 <= {{RECIP_W{1'b0}}, off_q} * RECIP_V;
    end
    if (cmd.mul2) begin
      qd <= REM_W'(q * DEPTH);
    end
    if (cmd.modr) begin
      offm <= (32'(rem) >= 32'(DEPTH)) ? rem - REM_W'(DEPTH) : rem;
    end
    if (cmd.base) begin
      paddr <= (sumb >= BW'(DEPTH)) ? PW'(sumb - BW'(DEPTH)) : PW'(sumb);
    end
    if (cmd.issue) begin
      paddr <= (paddr == LAST) ? '0 : paddr + 1'b1;
    end
    if (cmd.cap) begin
      acc[8 * cnt +: 8] <= rd_data;
      cnt <= cnt + 1'b1;
    end
    if (cmd.load) begin
      read_data      <= acc;
      data_valid     <= res_valid;
      write_accepted <= res_acc;
      occupancy      <= occ_w[CNT_W-1:0];
      free_space     <= free_w[CNT_W-1:0];
    end
  end

endmodule

[sv/brf_ctrl.sv]
// Controller of the byte ring FIFO: sequences clear, write, pop and peek steps.
// Depends on brf_pkg; commands brf_dpath and owns the result valid flag.
module brf_ctrl import brf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output brf_cmd_t cmd,
  input  brf_sts_t sts
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_MODR  = 4'd5;
  localparam logic [3:0] S_BASE  = 4'd6;
  localparam logic [3:0] S_ISSUE = 4'd7;
  localparam logic [3:0] S_CAP   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;
  logic       is_peek;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign req_stall = (state != S_IDLE);

  always_comb begin
    is_peek    = (sts.op == OP_PEEK8) || (sts.op == OP_PEEK16) || (sts.op == OP_PEEK32);
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_peek) begin
          state_next = S_MUL1;
        end else begin
          cmd.exec = 1'b1;
          if ((sts.op == OP_POP) && !sts.empty) begin
            state_next = S_CAP;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MODR;
      end
      S_MODR: begin
        cmd.modr   = 1'b1;
        state_next = S_BASE;
      end
      S_BASE: begin
        cmd.base   = 1'b1;
        state_next = S_ISSUE;
      end
      S_ISSUE: begin
        cmd.issue  = 1'b1;
        state_next = S_CAP;
      end
      S_CAP: begin
        cmd.cap    = 1'b1;
        state_next = (sts.cap_last || !is_peek) ? S_DONE : S_ISSUE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[sv/byte_ring_fifo_with_peek.sv]
// Top level of the byte ring FIFO with peek.
// Depends on brf_pkg, brf_ctrl and brf_dpath.
//
//   channel | handshake            | fields
//   req     | req_valid/req_stall  | operation data_byte burst_first write_length peek_offset
//   rsp     | rsp_valid/rsp_stall  | read_data data_valid write_accepted occupancy free_space
//
// Steps per item: write, empty pop or unused code pass through exec and done; a pop adds
// a capture step; a peek of n bytes forms its address in mul1, mul2, modr and base, then
// issues and captures each byte in turn through the single read port of the byte store.
// After reset the store is cleared one byte a cycle, with req_stall high.
// A stalled result holds in the output register; the next item is taken meanwhile
// and waits in its last step until the output register frees.
module byte_ring_fifo_with_peek import brf_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [OP_W-1:0]   operation,
  input  logic [BYTE_W-1:0] data_byte,
  input  logic              burst_first,
  input  logic [LEN_W-1:0]  write_length,
  input  logic [OFF_W-1:0]  peek_offset,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [DATA_W-1:0] read_data,
  output logic              data_valid,
  output logic              write_accepted,
  output logic [CNT_W-1:0]  occupancy,
  output logic [CNT_W-1:0]  free_space
);

  brf_cmd_t cmd;
  brf_sts_t sts;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  brf_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .operation      (operation),
    .data_byte      (data_byte),
    .burst_first    (burst_first),
    .write_length   (write_length),
    .peek_offset    (peek_offset),
    .read_data      (read_data),
    .data_valid     (data_valid),
    .write_accepted (write_accepted),
    .occupancy      (occupancy),
    .free_space     (free_space)
  );

endmodule

[sv/brf_checker.sv]
// Port-level checker of the byte ring FIFO, bound to the top level.
// Depends on brf_pkg and byte_ring_fifo_with_peek_macros.svh.
`include "byte_ring_fifo_with_peek_macros.svh"

module brf_checker import brf_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input logic [DATA_W-1:0] read_data,
  input logic              data_valid,
  input logic              write_accepted,
  input logic [CNT_W-1:0]  occupancy,
  input logic [CNT_W-1:0]  free_space
);

  `BRF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(read_data), "stalled result changed")
  `BRF_ASSERT_NOW(a_space_sum, rsp_valid, CNT_W'(occupancy + free_space) == CNT_W'(DEPTH - 1), "occupancy and free space disagree")
  `BRF_ASSERT_NOW(a_write_no_data, rsp_valid && write_accepted, !data_valid && (read_data == '0), "write result carries data")
  `BRF_ASSERT_NOW(a_invalid_zero, rsp_valid && !data_valid, read_data == '0, "invalid result has nonzero data")
  `BRF_ASSERT_NEXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "second item taken while busy")

endmodule

bind byte_ring_fifo_with_peek brf_checker #(.DEPTH(DEPTH)) u_brf_checker (.*);
